FILE: hdl/histogram_hash_partitioner_defines.svh
// histogram_hash_partitioner_defines.svh: assertion macros for the partitioner
// no dependencies; included by the top level
`ifndef HISTOGRAM_HASH_PARTITIONER_DEFINES_SVH
`define HISTOGRAM_HASH_PARTITIONER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HHP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define HHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/hhp_pkg.sv
// hhp_pkg: shared types and codes of the hash partitioner
// no dependencies
package hhp_pkg;

  // fixed field widths of the ports
  localparam int KEY_PORT_BITS  = 32;
  localparam int SLOT_PORT_BITS = 10;
  localparam int BKT_PORT_BITS  = 4;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_MOD,
    ST_LOAD_CNT,
    ST_PREFIX,
    ST_FETCH_KEY,
    ST_FETCH_CNT,
    ST_EMPTY
  } state_t;

endpackage

FILE: hdl/hhp_bucket_mod.sv
// hhp_bucket_mod: three-stage pipeline that computes key modulo NUM_BUCKETS
// depends on hhp_pkg
module hhp_bucket_mod #(
  parameter int NUM_BUCKETS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [hhp_pkg::KEY_PORT_BITS-1:0] key,
  output logic                              done,
  output logic [$clog2(NUM_BUCKETS)-1:0]    bucket
);
  import hhp_pkg::*;

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int HALF = KEY_PORT_BITS / 2;
  // 2^16 mod N folds the upper half onto the lower half
  localparam logic [7:0] FOLD = 8'((64'd1 << HALF) % NUM_BUCKETS);
  // reciprocal scaled by 2^33, rounded up: exact quotient for 25-bit values
  localparam logic [33:0] RECIP = 34'(((64'd1 << 33) / NUM_BUCKETS) + 64'd1);
  localparam logic [8:0] DIVISOR = 9'(NUM_BUCKETS);

  logic        v1, v2, v3;
  logic [24:0] x1;
  logic [24:0] x2;
  logic [23:0] quo;
  logic [58:0] prod;
  logic [32:0] qn;
  logic [24:0] rem;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign prod = 59'(x1) * 59'(RECIP);
  assign qn   = 33'(quo) * 33'(DIVISOR);
  assign rem  = x2 - qn[24:0];

  // fold, quotient by reciprocal, remainder
  always_ff @(posedge clk) begin
    if (start) begin
      x1 <= 25'(25'(key[KEY_PORT_BITS-1:HALF]) * 25'(FOLD)) + 25'(key[HALF-1:0]);
    end
    if (v1) begin
      quo <= prod[56:33];
      x2  <= x1;
    end
    if (v2) begin
      bucket <= rem[BW-1:0];
    end
  end

  assign done = v3;

endmodule

FILE: hdl/histogram_hash_partitioner.sv
// histogram_hash_partitioner: stable hash partition (histogram, prefix sum, scatter)
// load: per key, the 3-stage modulo pipeline, then a count read-modify-write
// fetch: key memory read, count memory read, update; the first fetch
// of a batch first runs the prefix sum over the count memory
// reset clears counters, flags and count valid bits at once; no clearing pass
// depends on hhp_pkg, hhp_bucket_mod and histogram_hash_partitioner_defines.svh
`include "histogram_hash_partitioner_defines.svh"

module histogram_hash_partitioner #(
  parameter int NUM_BUCKETS = 16,
  parameter int MAX_ITEMS   = 1024,
  parameter int KEY_BITS    = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cmd,
  input  logic [hhp_pkg::KEY_PORT_BITS-1:0]  key,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hhp_pkg::KEY_PORT_BITS-1:0]  key_out,
  output logic [hhp_pkg::SLOT_PORT_BITS-1:0] dest_slot,
  output logic [hhp_pkg::BKT_PORT_BITS-1:0]  bucket_id,
  output logic                               final_item,
  output logic                               status,
  output logic                               overflowed
);
  import hhp_pkg::*;

  localparam int SKW = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
  localparam int BW  = $clog2(NUM_BUCKETS);
  localparam int PW  = BW + 1;
  localparam int IW  = $clog2(MAX_ITEMS + 1);
  localparam int AW  = $clog2(MAX_ITEMS);
  localparam int EW  = SKW + BW;
  localparam logic [IW-1:0] CNT_MAX = IW'(MAX_ITEMS);
  localparam logic [PW-1:0] PIDX_END = PW'(NUM_BUCKETS);

  state_t state, state_next;

  // batch control
  logic [IW-1:0] item_count;
  logic [IW-1:0] read_index;
  logic          offsets_ready;
  logic          overflow_flag;
  logic [NUM_BUCKETS-1:0] cnt_vld;

  // prefix sweep
  logic [PW-1:0] pidx;
  logic          pv;
  logic [BW-1:0] pw_addr;
  logic [IW-1:0] run;

  // payload holding registers
  logic [SKW-1:0] key_reg;
  logic [SKW-1:0] fkey;
  logic [BW-1:0]  fbkt;
  logic [BW-1:0]  ld_bkt;

  // memories
  logic [EW-1:0] key_mem [MAX_ITEMS];
  logic [EW-1:0] key_rdata;
  logic [IW-1:0] cnt_mem [NUM_BUCKETS];
  logic [IW-1:0] cnt_rdata;
  logic          cnt_rvld;

  // decoded controls
  logic          accept;
  logic          ld_go;
  logic          ld_ovf;
  logic          out_free;
  logic          key_we;
  logic          cnt_rd_en;
  logic [BW-1:0] cnt_rd_addr;
  logic          cnt_we;
  logic [BW-1:0] cnt_wa;
  logic [IW-1:0] cnt_wd;
  logic [IW-1:0] cnt_cur;
  logic          emit_fetch;
  logic          emit_empty;
  logic          prefix_done;
  logic          last;
  logic [IW-1:0] read_next;

  logic          mod_done;
  logic [BW-1:0] mod_bucket;

  // bucket of an incoming key
  hhp_bucket_mod #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (ld_go),
    .key   (KEY_PORT_BITS'(key[SKW-1:0])),
    .done  (mod_done),
    .bucket(mod_bucket)
  );

  assign in_stall    = (state != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign ld_go       = accept && (cmd == CMD_LOAD) && !offsets_ready && (item_count != CNT_MAX);
  assign ld_ovf      = accept && (cmd == CMD_LOAD) && !offsets_ready && (item_count == CNT_MAX);
  assign out_free    = !out_valid || !out_stall;
  assign cnt_cur     = cnt_rvld ? cnt_rdata : '0;
  assign prefix_done = (pidx == PIDX_END) && !pv;
  assign read_next   = read_index + IW'(1);
  assign last        = (read_next >= item_count);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_FETCH) begin
            if (item_count == '0) begin
              state_next = ST_EMPTY;
            end else if (!offsets_ready) begin
              state_next = ST_PREFIX;
            end else begin
              state_next = ST_FETCH_KEY;
            end
          end else if (ld_go) begin
            state_next = ST_LOAD_MOD;
          end
        end
      end
      ST_LOAD_MOD: begin
        if (mod_done) begin
          state_next = ST_LOAD_CNT;
        end
      end
      ST_LOAD_CNT:  state_next = ST_IDLE;
      ST_PREFIX: begin
        if (prefix_done) begin
          state_next = ST_FETCH_KEY;
        end
      end
      ST_FETCH_KEY: state_next = ST_FETCH_CNT;
      ST_FETCH_CNT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory ports and result strobes
  always_comb begin
    key_we      = 1'b0;
    cnt_rd_en   = 1'b0;
    cnt_rd_addr = '0;
    cnt_we      = 1'b0;
    cnt_wa      = '0;
    cnt_wd      = '0;
    emit_fetch  = 1'b0;
    emit_empty  = 1'b0;
    unique case (state)
      ST_IDLE: begin
      end
      ST_LOAD_MOD: begin
        key_we      = mod_done;
        cnt_rd_en   = mod_done;
        cnt_rd_addr = mod_bucket;
      end
      ST_LOAD_CNT: begin
        cnt_we = 1'b1;
        cnt_wa = ld_bkt;
        cnt_wd = cnt_cur + IW'(1);
      end
      ST_PREFIX: begin
        cnt_rd_en   = (pidx < PIDX_END);
        cnt_rd_addr = pidx[BW-1:0];
        cnt_we      = pv;
        cnt_wa      = pw_addr;
        cnt_wd      = run;
      end
      ST_FETCH_KEY: begin
        cnt_rd_en   = 1'b1;
        cnt_rd_addr = key_rdata[EW-1:SKW];
      end
      ST_FETCH_CNT: begin
        cnt_we     = out_free;
        cnt_wa     = fbkt;
        cnt_wd     = cnt_cur + IW'(1);
        emit_fetch = out_free;
      end
      ST_EMPTY: begin
        emit_empty = out_free;
      end
      default: begin
      end
    endcase
  end

  // sequencer and batch state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      item_count    <= '0;
      read_index    <= '0;
      offsets_ready <= 1'b0;
      overflow_flag <= 1'b0;
      cnt_vld       <= '0;
      pidx          <= '0;
      pv            <= 1'b0;
      run           <= '0;
    end else begin
      state <= state_next;
      if (ld_ovf) begin
        overflow_flag <= 1'b1;
      end
      if (state == ST_LOAD_CNT) begin
        item_count <= item_count + IW'(1);
      end
      // prefix sweep: read one bucket, write the previous one
      if (state == ST_IDLE) begin
        pidx <= '0;
        pv   <= 1'b0;
        run  <= '0;
      end else if (state == ST_PREFIX) begin
        if (cnt_rd_en) begin
          pidx <= pidx + PW'(1);
        end
        pv <= cnt_rd_en;
        if (pv) begin
          run <= run + cnt_cur;
        end
        if (prefix_done) begin
          offsets_ready <= 1'b1;
        end
      end
      if (emit_fetch && last) begin
        // end of batch: back to the reset state
        item_count    <= '0;
        read_index    <= '0;
        offsets_ready <= 1'b0;
        overflow_flag <= 1'b0;
        cnt_vld       <= '0;
      end else begin
        if (cnt_we) begin
          cnt_vld[cnt_wa] <= 1'b1;
        end
        if (emit_fetch) begin
          read_index <= read_next;
        end
      end
    end
  end

  // payload holding registers
  always_ff @(posedge clk) begin
    if (ld_go) begin
      key_reg <= key[SKW-1:0];
    end
    if (state == ST_LOAD_MOD && mod_done) begin
      ld_bkt <= mod_bucket;
    end
    if (state == ST_PREFIX && cnt_rd_en) begin
      pw_addr <= cnt_rd_addr;
    end
    if (state == ST_FETCH_KEY) begin
      fkey <= key_rdata[SKW-1:0];
      fbkt <= key_rdata[EW-1:SKW];
    end
  end

  // key store: key with its bucket, read at the fetch position every cycle
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[item_count[AW-1:0]] <= {mod_bucket, key_reg};
    end
    key_rdata <= key_mem[read_index[AW-1:0]];
  end

  // bucket count store
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_rd_en) begin
      cnt_rdata <= cnt_mem[cnt_rd_addr];
      cnt_rvld  <= cnt_vld[cnt_rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fetch || emit_empty) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fetch) begin
      key_out    <= KEY_PORT_BITS'(fkey);
      dest_slot  <= SLOT_PORT_BITS'(cnt_cur);
      bucket_id  <= BKT_PORT_BITS'(fbkt);
      final_item <= last;
      status     <= STATUS_OK;
      overflowed <= overflow_flag;
    end else if (emit_empty) begin
      key_out    <= '0;
      dest_slot  <= '0;
      bucket_id  <= '0;
      final_item <= 1'b0;
      status     <= STATUS_EMPTY;
      overflowed <= overflow_flag;
    end
  end

  // checks
  `HHP_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, item_count <= CNT_MAX, "item count above capacity")
  `HHP_ASSERT_NOW(a_read_in_batch, clk, rst, offsets_ready, read_index < item_count, "read index past batch")
  `HHP_ASSERT_NEXT(a_batch_clear, clk, rst, emit_fetch && last, (item_count == '0) && !offsets_ready && (cnt_vld == '0), "batch not cleared after last key")
  `HHP_ASSERT_NEXT(a_load_ignored, clk, rst, accept && (cmd == CMD_LOAD) && offsets_ready, (state == ST_IDLE) && $stable(item_count), "load changed state during fetch phase")

endmodule
